@@ src/ilc_pkg.sv @@
// Package for the interrupt level controller: command codes, register offsets
// and the request and response structs.
// No dependencies.
package ilc_pkg;

	localparam int REGISTER_COUNT_DEFAULT = 32;
	localparam int LINE_COUNT = 4;
	localparam int LEVEL_W = 3;

	localparam logic [4:0] ACK_REG_BASE = 5'h04;
	localparam logic [4:0] OTHER_REG_BASE = 5'h08;
	localparam logic [4:0] SOUND_RUN_REG = 5'h16;
	localparam logic [4:0] DSP_CONTROL_REG = 5'h1C;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ = 2'd1,
		CMD_VBLANK = 2'd2,
		CMD_SCANLINE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t command;
		logic [4:0] reg_offset;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [LEVEL_W-1:0] interrupt_level;
		logic [LINE_COUNT-1:0] pending_lines;
		logic [LINE_COUNT-1:0] enabled_lines;
		logic sound_cpu_run;
		logic [7:0] dsp_control;
	} rsp_t;

endpackage

@@ src/interrupt_level_controller.sv @@
// A request transfer moves into stage s1, then into the output register.
// Throughput: one request per cycle while responses are taken; the register file
// memory is read at the request transfer and its registered data feeds the
// output stage. A stalled response does not stop the next request: s1 holds it.
// Reset clears line state, flags and the per-entry valid bits at once; an entry
// never written reads as zero, so no clearing pass is needed.
module interrupt_level_controller
	import ilc_pkg::*;
#(
	parameter int REGISTER_COUNT = REGISTER_COUNT_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(REGISTER_COUNT);

	logic [7:0] reg_mem_q [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] reg_vld_q;

	logic [LINE_COUNT-1:0] en_q, en_n;
	logic [LINE_COUNT-1:0] pend_q, pend_n;
	logic [LINE_COUNT-1:0][LEVEL_W-1:0] lvl_q, lvl_n;
	logic snd_q, snd_n;
	logic [7:0] dsp_q, dsp_n;

	logic valid_s1;
	logic rd_vld_s1;
	logic [7:0] rd_data_s1;
	logic [LINE_COUNT-1:0] en_s1, pend_s1;
	logic [LINE_COUNT-1:0][LEVEL_W-1:0] lvl_s1;
	logic snd_s1;
	logic [7:0] dsp_s1;

	logic out_valid_q;
	rsp_t out_q;

	logic adv, acc;
	logic [IDX_W-1:0] addr;
	logic [LEVEL_W-1:0] best;
	logic [1:0] line;

	assign addr = IDX_W'(req.reg_offset);
	assign line = req.reg_offset[1:0];
	assign adv = valid_s1 && (!out_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign acc = req_valid && req_ready;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	// Line state after the incoming request has taken effect.
	always_comb begin
		en_n = en_q;
		pend_n = pend_q;
		lvl_n = lvl_q;
		snd_n = snd_q;
		dsp_n = dsp_q;
		case (req.command)
			CMD_WRITE: begin
				if (req.reg_offset < ACK_REG_BASE) begin
					lvl_n[line] = req.write_data[LEVEL_W-1:0];
					en_n[line] = |req.write_data[LEVEL_W-1:0];
					pend_n = pend_q & en_n;
				end else if (req.reg_offset < OTHER_REG_BASE) begin
					pend_n[line] = 1'b0;
				end else if (req.reg_offset == SOUND_RUN_REG) begin
					snd_n = |req.write_data;
				end else if (req.reg_offset == DSP_CONTROL_REG) begin
					dsp_n = req.write_data;
				end
			end
			CMD_READ: begin
			end
			CMD_VBLANK: begin
				pend_n[0] = pend_q[0] | en_q[0];
			end
			CMD_SCANLINE: begin
				pend_n[1] = pend_q[1] | en_q[1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			pend_q <= '0;
			lvl_q <= '0;
			snd_q <= 1'b0;
			dsp_q <= '0;
			reg_vld_q <= '0;
		end else if (acc) begin
			en_q <= en_n;
			pend_q <= pend_n;
			lvl_q <= lvl_n;
			snd_q <= snd_n;
			dsp_q <= dsp_n;
			if (req.command == CMD_WRITE) begin
				reg_vld_q[addr] <= 1'b1;
			end
		end
	end

	// Register file: one write and one registered read per cycle, on taken requests.
	// One request moves per edge, so a read never meets a write to the same entry.
	always_ff @(posedge clk) begin
		if (acc) begin
			if (req.command == CMD_WRITE) begin
				reg_mem_q[addr] <= req.write_data;
			end
			rd_data_s1 <= reg_mem_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_vld_s1 <= (req.command == CMD_READ) && reg_vld_q[addr];
			en_s1 <= en_n;
			pend_s1 <= pend_n;
			lvl_s1 <= lvl_n;
			snd_s1 <= snd_n;
			dsp_s1 <= dsp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		best = '0;
		for (int i = 0; i < LINE_COUNT; i++) begin
			if (pend_s1[i] && (lvl_s1[i] > best)) begin
				best = lvl_s1[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.read_data <= rd_vld_s1 ? rd_data_s1 : 8'h00;
			out_q.interrupt_level <= best;
			out_q.pending_lines <= pend_s1;
			out_q.enabled_lines <= en_s1;
			out_q.sound_cpu_run <= snd_s1;
			out_q.dsp_control <= dsp_s1;
		end
	end

endmodule

@@ src/ilc_checker.sv @@
// Port-level checks for the interrupt level controller, bound to its top level.
// Depends on ilc_pkg and interrupt_level_controller.
module ilc_checker
	import ilc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A request waiting for its transfer stays asserted and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	// A response waiting for its transfer must not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A pending line is always an enabled line.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.pending_lines & ~rsp.enabled_lines) == '0)
		else $error("pending line that is not enabled");

	// A nonzero level needs a pending line, and a pending line has a nonzero level.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.interrupt_level != '0) == (rsp.pending_lines != '0)))
		else $error("interrupt level disagrees with pending lines");

	// With the output stage empty the block always takes a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request blocked while output is empty");

endmodule

bind interrupt_level_controller ilc_checker u_ilc_checker (.*);

@@ tb/tb_interrupt_level_controller.sv @@
// Testbench for interrupt_level_controller: a directed table, then random writes,
// reads and events, each response checked against a behavioral predictor or its table row.
// Depends on ilc_pkg and interrupt_level_controller.
`timescale 1ns / 100ps

module tb_interrupt_level_controller;
	import ilc_pkg::*;

	localparam logic [4:0] LEVEL_REG_BASE = 5'h00;
	localparam logic [4:0] LAST_REG = 5'h1F;
	localparam int RANDOM_ITEMS = 700;
	localparam int NUM_DIRECTED = 25;
	localparam rsp_t NO_RSP = '0;

	typedef struct packed {
		logic has_literal;
		req_t req;
		rsp_t rsp;
	} directed_row_t;

	// Rows with has_literal set carry their response as written; the rest use the predictor.
	localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{1'b1, '{CMD_READ, LAST_REG, 8'h00}, NO_RSP},
		'{1'b1, '{CMD_VBLANK, LAST_REG, 8'hFF}, NO_RSP},
		'{1'b1, '{CMD_WRITE, DSP_CONTROL_REG, 8'hFF}, '{8'h00, 3'd0, 4'h0, 4'h0, 1'b0, 8'hFF}},
		'{1'b1, '{CMD_READ, DSP_CONTROL_REG, 8'h00}, '{8'hFF, 3'd0, 4'h0, 4'h0, 1'b0, 8'hFF}},
		'{1'b1, '{CMD_WRITE, SOUND_RUN_REG, 8'h80}, '{8'h00, 3'd0, 4'h0, 4'h0, 1'b1, 8'hFF}},
		'{1'b1, '{CMD_WRITE, SOUND_RUN_REG, 8'h00}, '{8'h00, 3'd0, 4'h0, 4'h0, 1'b0, 8'hFF}},
		'{1'b1, '{CMD_WRITE, DSP_CONTROL_REG, 8'h00}, NO_RSP},
		'{1'b0, '{CMD_WRITE, LEVEL_REG_BASE, 8'h07}, NO_RSP},
		'{1'b0, '{CMD_WRITE, LEVEL_REG_BASE + 5'd1, 8'hF3}, NO_RSP},
		'{1'b0, '{CMD_WRITE, LEVEL_REG_BASE + 5'd2, 8'h05}, NO_RSP},
		'{1'b0, '{CMD_WRITE, LEVEL_REG_BASE + 5'd3, 8'hFF}, NO_RSP},
		'{1'b0, '{CMD_VBLANK, LAST_REG, 8'hFF}, NO_RSP},
		'{1'b0, '{CMD_SCANLINE, 5'h0A, 8'h55}, NO_RSP},
		'{1'b0, '{CMD_WRITE, ACK_REG_BASE, 8'hFF}, NO_RSP},
		'{1'b0, '{CMD_READ, LEVEL_REG_BASE, 8'h00}, NO_RSP},
		'{1'b0, '{CMD_WRITE, LEVEL_REG_BASE + 5'd1, 8'h08}, NO_RSP},
		'{1'b0, '{CMD_SCANLINE, LEVEL_REG_BASE, 8'h00}, NO_RSP},
		'{1'b0, '{CMD_WRITE, ACK_REG_BASE + 5'd1, 8'h00}, NO_RSP},
		'{1'b0, '{CMD_WRITE, ACK_REG_BASE + 5'd2, 8'hAA}, NO_RSP},
		'{1'b0, '{CMD_WRITE, ACK_REG_BASE + 5'd3, 8'hFF}, NO_RSP},
		'{1'b0, '{CMD_WRITE, OTHER_REG_BASE, 8'hAA}, NO_RSP},
		'{1'b0, '{CMD_READ, OTHER_REG_BASE, 8'h00}, NO_RSP},
		'{1'b0, '{CMD_WRITE, LAST_REG, 8'h55}, NO_RSP},
		'{1'b0, '{CMD_READ, LAST_REG, 8'h00}, NO_RSP},
		'{1'b0, '{CMD_WRITE, LEVEL_REG_BASE + 5'd2, 8'h00}, NO_RSP}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Predictor state.
	logic [7:0] ctl_bytes [REGISTER_COUNT_DEFAULT];
	logic [LINE_COUNT-1:0] line_en = '0;
	logic [LINE_COUNT-1:0] line_pend = '0;
	logic sound_run = 1'b0;
	logic [7:0] dsp_byte = '0;

	rsp_t expected_rsp_q [$];
	int mismatch_count = 0;
	int responses_seen = 0;
	int write_count = 0;
	int read_count = 0;
	int event_count = 0;

	interrupt_level_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		foreach (ctl_bytes[i]) ctl_bytes[i] = '0;
	end

	task automatic predict_response(input req_t r, output rsp_t p);
		logic [LEVEL_W-1:0] best;
		logic [LEVEL_W-1:0] lvl;
		best = '0;
		p = '0;
		case (r.command)
			CMD_WRITE: begin
				if (r.reg_offset < ACK_REG_BASE) begin
					line_en[r.reg_offset[1:0]] = (r.write_data[LEVEL_W-1:0] != '0);
					line_pend = line_pend & line_en;
				end else if (r.reg_offset < OTHER_REG_BASE) begin
					line_pend[r.reg_offset[1:0]] = 1'b0;
				end else if (r.reg_offset == SOUND_RUN_REG) begin
					sound_run = (r.write_data != '0);
				end else if (r.reg_offset == DSP_CONTROL_REG) begin
					dsp_byte = r.write_data;
				end
				ctl_bytes[r.reg_offset] = r.write_data;
			end
			CMD_READ: p.read_data = ctl_bytes[r.reg_offset];
			CMD_VBLANK: if (line_en[0]) line_pend[0] = 1'b1;
			default: if (line_en[1]) line_pend[1] = 1'b1;
		endcase
		for (int line = 0; line < LINE_COUNT; line++) begin
			lvl = ctl_bytes[line][LEVEL_W-1:0];
			if (line_pend[line] && lvl > best) best = lvl;
		end
		p.interrupt_level = best;
		p.pending_lines = line_pend;
		p.enabled_lines = line_en;
		p.sound_cpu_run = sound_run;
		p.dsp_control = dsp_byte;
	endtask

	// Most traffic is line setup, acknowledges and events so that lines go pending
	// and get cleared often; the rest is reads and writes anywhere.
	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		r.command = CMD_WRITE;
		r.reg_offset = 5'($urandom);
		r.write_data = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			r.reg_offset = LEVEL_REG_BASE + 5'($urandom_range(0, 3));
			if ($urandom_range(0, 4) == 0) r.write_data[LEVEL_W-1:0] = '0;
		end else if (pick < 37) begin
			r.reg_offset = ACK_REG_BASE + 5'($urandom_range(0, 3));
		end else if (pick < 55) begin
			r.command = CMD_VBLANK;
		end else if (pick < 70) begin
			r.command = CMD_SCANLINE;
		end else if (pick < 85) begin
			r.command = CMD_READ;
		end else if (pick < 90) begin
			r.reg_offset = $urandom_range(0, 1) ? SOUND_RUN_REG : DSP_CONTROL_REG;
			if ($urandom_range(0, 2) == 0) r.write_data = '0;
		end
		return r;
	endfunction

	task automatic check_response(input rsp_t got);
		rsp_t want;
		if (expected_rsp_q.size() == 0) begin
			$display("%0t: response with nothing expected: %p", $time, got);
			mismatch_count++;
		end else begin
			want = expected_rsp_q.pop_front();
			if (got.read_data !== want.read_data)
				$display("%0t: read_data expected %h actual %h", $time,
					want.read_data, got.read_data);
			if (got.interrupt_level !== want.interrupt_level)
				$display("%0t: interrupt_level expected %0d actual %0d", $time,
					want.interrupt_level, got.interrupt_level);
			if (got.pending_lines !== want.pending_lines)
				$display("%0t: pending_lines expected %b actual %b", $time,
					want.pending_lines, got.pending_lines);
			if (got.enabled_lines !== want.enabled_lines)
				$display("%0t: enabled_lines expected %b actual %b", $time,
					want.enabled_lines, got.enabled_lines);
			if (got.sound_cpu_run !== want.sound_cpu_run)
				$display("%0t: sound_cpu_run expected %b actual %b", $time,
					want.sound_cpu_run, got.sound_cpu_run);
			if (got.dsp_control !== want.dsp_control)
				$display("%0t: dsp_control expected %h actual %h", $time,
					want.dsp_control, got.dsp_control);
			if (got !== want) mismatch_count++;
		end
	endtask

	// Response side: random stall before each transfer, with stretches of none.
	initial begin
		int unsigned stall;
		bit steady;
		steady = 1'b0;
		wait (arst_n);
		forever begin
			if (responses_seen % 64 == 0) steady = ($urandom_range(0, 2) == 0);
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			responses_seen++;
			check_response(rsp);
		end
	end

	initial begin
		int unsigned gap;
		bit steady;
		req_t item;
		rsp_t predicted;
		steady = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NUM_DIRECTED + RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) steady = ($urandom_range(0, 2) == 0);
			if (i < NUM_DIRECTED) item = DIRECTED_ROWS[i].req;
			else item = random_request();
			gap = steady ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req_valid <= 1'b1;
			req <= item;
			do @(posedge clk); while (!req_ready);
			predict_response(item, predicted);
			if (i < NUM_DIRECTED) begin
				if (DIRECTED_ROWS[i].has_literal) predicted = DIRECTED_ROWS[i].rsp;
			end
			expected_rsp_q.push_back(predicted);
			case (item.command)
				CMD_WRITE: write_count++;
				CMD_READ: read_count++;
				default: event_count++;
			endcase
		end
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		// Catch any response that should not be there.
		repeat (10) @(posedge clk);
		$display("Sent %0d transfers (%0d directed): %0d writes, %0d reads, %0d events.",
			NUM_DIRECTED + RANDOM_ITEMS, NUM_DIRECTED, write_count, read_count, event_count);
		$display("Checked %0d responses, %0d with a mismatch.", responses_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb_interrupt_level_controller passed");
		end else begin
			$display("tb_interrupt_level_controller failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout with %0d responses outstanding", $time, expected_rsp_q.size());
		$display("tb_interrupt_level_controller failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/ilc_pkg.sv
src/interrupt_level_controller.sv
src/ilc_checker.sv
tb/tb_interrupt_level_controller.sv
